// File: src/app_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phaser shared definitions
// Command codes, controller/datapath interface types and saturation helper.
// ----------------------------------------------------------------------------
package app_pkg;

    // Width of the stage counter, enough for the largest cascade.
    localparam int STAGE_W = 4;
    localparam int OP_W    = 3;

    // Datapath operation codes.
    localparam logic [OP_W-1:0] OP_NONE = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 3'd1;
    localparam logic [OP_W-1:0] OP_COEF = 3'd2;
    localparam logic [OP_W-1:0] OP_FB   = 3'd3;
    localparam logic [OP_W-1:0] OP_AP1  = 3'd4;
    localparam logic [OP_W-1:0] OP_AP2  = 3'd5;
    localparam logic [OP_W-1:0] OP_MIX1 = 3'd6;
    localparam logic [OP_W-1:0] OP_MIX2 = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] REG_INC   = 2'd0;
    localparam logic [1:0] REG_DEPTH = 2'd1;
    localparam logic [1:0] REG_FB    = 2'd2;
    localparam logic [1:0] REG_MIX   = 2'd3;

    localparam int CFG_W = 19;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [STAGE_W-1:0] stage;
    } app_cmd_t;

    typedef struct packed {
        logic out_busy;
    } app_status_t;

    // Saturate a wide signed value to 24 bits.
    function automatic logic signed [23:0] sat24(input logic signed [51:0] v);
        logic signed [23:0] r;
        if (v > 52'sd8388607) begin
            r = 24'sh7FFFFF;
        end
        else if (v < -52'sd8388608) begin
            r = 24'sh800000;
        end
        else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// File: src/allpass_phaser_effect_top.sv
`timescale 1ns / 1ps
// Each sample is sequenced through coefficient fetch, feedback, each allpass stage twice and
// the mix; a new sample is accepted only after the previous one's final mix step, since the single
// shared multiplier serves feedback, each allpass stage twice, and the mix.
// A stalled result holds the next sample at its final mix step until it is taken.
// Reset (rst_n, asynchronous, active low) clears the LFO phase, feedback sample,
// allpass state and output valid, and loads the default configuration values.
// ----------------------------------------------------------------------------
// Allpass phaser effect top level
// Triangle-LFO swept allpass cascade with feedback and dry/wet mix.
// ----------------------------------------------------------------------------
module allpass_phaser_effect_top #(
    parameter int STAGE_COUNT      = 4,
    parameter int SAMPLE_RATE_HZ   = 48000,
    parameter int SWEEP_MIN_HZ     = 100,
    parameter int SWEEP_MAX_HZ     = 4000,
    parameter int COEFF_TABLE_BITS = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [23:0]        dry_sample,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [23:0]        mixed_sample,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [app_pkg::CFG_W-1:0] cfg_data
);
    import app_pkg::*;

    app_cmd_t    cmd;
    app_status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    app_ctrl #(
        .STAGE_COUNT(STAGE_COUNT)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    app_dp #(
        .STAGE_COUNT     (STAGE_COUNT),
        .SAMPLE_RATE_HZ  (SAMPLE_RATE_HZ),
        .SWEEP_MIN_HZ    (SWEEP_MIN_HZ),
        .SWEEP_MAX_HZ    (SWEEP_MAX_HZ),
        .COEFF_TABLE_BITS(COEFF_TABLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .dry_sample  (dry_sample),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mixed_sample(mixed_sample)
    );

endmodule

// File: src/app_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phaser controller
// Sequences one sample through the shared-multiplier datapath.
// ----------------------------------------------------------------------------
module app_ctrl #(
    parameter int STAGE_COUNT = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  app_pkg::app_status_t status,
    output app_pkg::app_cmd_t    cmd
);
    import app_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COEF = 3'd1;
    localparam logic [2:0] S_FB   = 3'd2;
    localparam logic [2:0] S_AP1  = 3'd3;
    localparam logic [2:0] S_AP2  = 3'd4;
    localparam logic [2:0] S_MIX1 = 3'd5;
    localparam logic [2:0] S_MIX2 = 3'd6;

    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(STAGE_COUNT - 1);

    logic [2:0]         state_reg, state_next;
    logic [STAGE_W-1:0] stage_reg, stage_next;

    // Next-state and command decode.
    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.stage  = stage_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_COEF;
                end
            end
            S_COEF:
            begin
                cmd.op     = OP_COEF;
                state_next = S_FB;
            end
            S_FB:
            begin
                cmd.op     = OP_FB;
                stage_next = '0;
                state_next = S_AP1;
            end
            S_AP1:
            begin
                cmd.op     = OP_AP1;
                state_next = S_AP2;
            end
            S_AP2:
            begin
                cmd.op = OP_AP2;
                if (stage_reg == LAST_STAGE)
                begin
                    state_next = S_MIX1;
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    state_next = S_AP1;
                end
            end
            S_MIX1:
            begin
                cmd.op     = OP_MIX1;
                state_next = S_MIX2;
            end
            S_MIX2:
            begin
                // Hold here until the output register can take the result.
                if (!status.out_busy)
                begin
                    cmd.op     = OP_MIX2;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
        end
    end

endmodule

// File: src/app_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phaser datapath
// Configuration registers, LFO, coefficient table, allpass state, one
// shared multiplier and the output register.
// ----------------------------------------------------------------------------
module app_dp #(
    parameter int STAGE_COUNT      = 4,
    parameter int SAMPLE_RATE_HZ   = 48000,
    parameter int SWEEP_MIN_HZ     = 100,
    parameter int SWEEP_MAX_HZ     = 4000,
    parameter int COEFF_TABLE_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  app_pkg::app_cmd_t           cmd,
    output app_pkg::app_status_t        status,
    input  logic signed [23:0]          dry_sample,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [app_pkg::CFG_W-1:0]   cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [23:0]          mixed_sample
);
    import app_pkg::*;

    localparam int TABLE_SIZE = 1 << COEFF_TABLE_BITS;
    localparam int SW         = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned LN2_Q30     = 64'd744261118;

    localparam longint unsigned INC_MIN =
        (64'd4294967296 + 64'd10 * SAMPLE_RATE_HZ) / (64'd20 * SAMPLE_RATE_HZ);
    localparam longint unsigned INC_MAX =
        (64'd21474836480 + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ;
    localparam longint unsigned INC_RESET =
        (64'd2147483648 + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ;

    // ------------------------------------------------------------------
    // Elaboration-time coefficient table construction.
    // ------------------------------------------------------------------

    // Unsigned quotient by restoring shift and subtract.
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q, r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint log2_q30(input longint unsigned n_in);
        longint unsigned n, m, r;
        int k;
        n = (n_in == 0) ? 64'd1 : n_in;
        k = 0;
        while (k < 31 && (n >> (k + 1)) != 0) k++;
        m = (k <= 30) ? (n << (30 - k)) : (n >> (k - 30));
        r = longint'(k) << 30;
        for (int i = 30; i > 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= 2 * ONE_Q30)
            begin
                m = m >> 1;
                r = r | (64'd1 << (i - 1));
            end
        end
        return longint'(r);
    endfunction

    function automatic longint unsigned exp2_frac_q30(input longint unsigned f);
        longint unsigned u, term, sum;
        u    = (f * LN2_Q30) >> 30;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int k = 1; k <= 15; k++)
        begin
            term = udiv64((term * u) >> 30, 64'(k));
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic logic signed [23:0] coeff_for(input longint unsigned th_in);
        longint unsigned theta, th2, ts, tc;
        longint s, c, num, den, a, scaled_num;
        theta = (th_in > HALF_PI_Q30) ? HALF_PI_Q30 : th_in;
        th2   = (theta * theta) >> 30;
        ts    = theta;
        s     = longint'(theta);
        tc    = ONE_Q30;
        c     = longint'(ONE_Q30);
        for (int k = 1; k <= 8; k++)
        begin
            ts = udiv64((ts * th2) >> 30, 64'((2 * k) * (2 * k + 1)));
            tc = udiv64((tc * th2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if ((k & 1) == 1)
            begin
                s = s - longint'(ts);
                c = c - longint'(tc);
            end
            else
            begin
                s = s + longint'(ts);
                c = c + longint'(tc);
            end
        end
        num = s - c;
        den = s + c;
        if (den < 1) den = 1;
        // Quotient truncated toward zero.
        scaled_num = num * 8388608;
        if (scaled_num < 0)
        begin
            a = -longint'(udiv64(64'(-scaled_num), 64'(den)));
        end
        else
        begin
            a = longint'(udiv64(64'(scaled_num), 64'(den)));
        end
        return sat24(52'(a));
    endfunction

    function automatic logic signed [23:0] coeff_entry(input int i);
        longint lmin, lmax, span, top, y;
        longint unsigned e, p, fq16, theta;
        lmin = log2_q30(SWEEP_MIN_HZ);
        lmax = log2_q30(SWEEP_MAX_HZ);
        span = lmax - lmin;
        top  = TABLE_SIZE - 1;
        y    = lmin + longint'(udiv64(64'(span * i), 64'(top)));
        if (y < 0) y = 0;
        e = longint'(unsigned'(y)) >> 30;
        if (e > 16) e = 16;
        p    = exp2_frac_q30(y & (ONE_Q30 - 1));
        fq16 = (p << e) >> 14;
        if (fq16 > 64'h7FFFFFFF) fq16 = 64'h7FFFFFFF;
        theta = udiv64(fq16 * PI_Q30, 64'(SAMPLE_RATE_HZ)) >> 16;
        return coeff_for(theta);
    endfunction

    logic signed [23:0] rom_w [TABLE_SIZE];

    for (genvar gi = 0; gi < TABLE_SIZE; gi++)
    begin : g_rom
        localparam logic signed [23:0] CV = coeff_entry(gi);
        assign rom_w[gi] = CV;
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    logic [18:0]        inc_reg;
    logic [16:0]        depth_reg;
    logic signed [15:0] fbg_reg;
    logic [16:0]        mix_reg;
    logic [31:0]        phase_reg;
    logic signed [23:0] fb_sample_reg;
    logic signed [23:0] z_reg [STAGE_COUNT];
    logic signed [23:0] dry_reg;
    logic signed [23:0] x_reg;
    logic signed [23:0] y_reg;
    logic signed [23:0] coef_reg;
    logic [COEFF_TABLE_BITS-1:0] idx_reg;
    logic signed [49:0] acc_reg;
    logic signed [23:0] out_reg;
    logic               out_valid_reg;

    // ------------------------------------------------------------------
    // Clamped configuration values.
    // ------------------------------------------------------------------
    logic [16:0]        depth_c;
    logic [16:0]        mix_c;
    logic signed [15:0] g_c;
    logic [31:0]        inc_c;

    always_comb
    begin
        depth_c = (depth_reg > 17'd65536) ? 17'd65536 : depth_reg;
        mix_c   = (mix_reg > 17'd65536) ? 17'd65536 : mix_reg;
        if (fbg_reg > 16'sd31129)
        begin
            g_c = 16'sd31129;
        end
        else if (fbg_reg < -16'sd31129)
        begin
            g_c = -16'sd31129;
        end
        else
        begin
            g_c = fbg_reg;
        end
        if (64'(inc_reg) < INC_MIN)
        begin
            inc_c = 32'(INC_MIN);
        end
        else if (64'(inc_reg) > INC_MAX)
        begin
            inc_c = 32'(INC_MAX);
        end
        else
        begin
            inc_c = 32'(inc_reg);
        end
    end

    // ------------------------------------------------------------------
    // LFO: triangle, depth scaling and table index.
    // ------------------------------------------------------------------
    logic [32:0]               phase_neg;
    logic [16:0]               lfo;
    logic [33:0]               scaled_full;
    logic [17:0]               scaled;
    logic [COEFF_TABLE_BITS:0] idx_wide;
    logic [COEFF_TABLE_BITS-1:0] idx;

    always_comb
    begin
        phase_neg = 33'h1_0000_0000 - {1'b0, phase_reg};
        if (!phase_reg[31])
        begin
            lfo = phase_reg[31:15];
        end
        else
        begin
            lfo = phase_neg[31:15];
        end
        scaled_full = lfo * depth_c;
        scaled      = scaled_full[33:16];
        idx_wide    = scaled[16:16-COEFF_TABLE_BITS];
        if (idx_wide[COEFF_TABLE_BITS])
        begin
            idx = '1;
        end
        else
        begin
            idx = idx_wide[COEFF_TABLE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier with operand selection.
    // ------------------------------------------------------------------
    logic signed [24:0] op_a;
    logic signed [24:0] op_b;
    logic signed [49:0] prod;
    logic signed [23:0] z_sel;

    assign z_sel = z_reg[cmd.stage[SW-1:0]];

    always_comb
    begin
        op_a = 25'(x_reg);
        op_b = 25'(coef_reg);
        case (cmd.op)
            OP_FB:
            begin
                op_a = 25'(fb_sample_reg);
                op_b = 25'(g_c);
            end
            OP_AP1:
            begin
                op_a = 25'(coef_reg);
                op_b = 25'(x_reg);
            end
            OP_AP2:
            begin
                op_a = 25'(coef_reg);
                op_b = 25'(y_reg);
            end
            OP_MIX1:
            begin
                op_a = 25'(dry_reg);
                op_b = $signed({7'd0, 18'd65536 - {1'b0, mix_c}});
            end
            OP_MIX2:
            begin
                op_a = 25'(x_reg);
                op_b = $signed({8'd0, mix_c});
            end
            default:
            begin
                op_a = 25'(x_reg);
                op_b = 25'(coef_reg);
            end
        endcase
        prod = op_a * op_b;
    end

    // Rounded results for each operation.
    logic signed [51:0] rnd15;
    logic signed [51:0] rnd23;
    logic signed [51:0] mix_sum;
    logic signed [23:0] fb_x;
    logic signed [23:0] ap_y;
    logic signed [23:0] ap_z;
    logic signed [23:0] mix_y;

    always_comb
    begin
        rnd15   = (52'(prod) + 52'sd16384) >>> 15;
        rnd23   = (52'(prod) + 52'sd4194304) >>> 23;
        mix_sum = (52'(acc_reg) + 52'(prod) + 52'sd32768) >>> 16;
        fb_x    = sat24(52'(dry_reg) + rnd15);
        ap_y    = sat24(52'(z_sel) - rnd23);
        ap_z    = sat24(52'(x_reg) + rnd23);
        mix_y   = sat24(mix_sum);
    end

    // Configuration and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg       <= 19'(INC_RESET);
            depth_reg     <= 17'd32768;
            fbg_reg       <= '0;
            mix_reg       <= 17'd32768;
            phase_reg     <= '0;
            fb_sample_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STAGE_COUNT; i++)
            begin
                z_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_INC:   inc_reg   <= cfg_data;
                    REG_DEPTH: depth_reg <= cfg_data[16:0];
                    REG_FB:    fbg_reg   <= cfg_data[15:0];
                    REG_MIX:   mix_reg   <= cfg_data[16:0];
                    default:   inc_reg   <= inc_reg;
                endcase
            end
            if (cmd.op == OP_LOAD)
            begin
                phase_reg <= phase_reg + inc_c;
            end
            if (cmd.op == OP_AP2)
            begin
                z_reg[cmd.stage[SW-1:0]] <= ap_z;
            end
            if (cmd.op == OP_MIX1)
            begin
                fb_sample_reg <= x_reg;
            end
            // Output register: loaded by the final mix, freed by a transaction.
            if (cmd.op == OP_MIX2)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                dry_reg <= dry_sample;
                idx_reg <= idx;
            end
            OP_COEF:
            begin
                coef_reg <= rom_w[idx_reg];
            end
            OP_FB:
            begin
                x_reg <= fb_x;
            end
            OP_AP1:
            begin
                y_reg <= ap_y;
            end
            OP_AP2:
            begin
                x_reg <= y_reg;
            end
            OP_MIX1:
            begin
                acc_reg <= prod;
            end
            OP_MIX2:
            begin
                out_reg <= mix_y;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign mixed_sample    = out_reg;

endmodule

// File: src/app_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phaser port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module app_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] mixed_sample,
    input logic        cfg_ready
);

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(mixed_sample))
        else $error("result changed while stalled");

    // After an input transaction in_ready stays low while the sample is in progress.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input accepted while a sample is in progress");

    // No result appears in the cycle right after an input transaction.
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    // The configuration port never stalls.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind allpass_phaser_effect_top app_checker u_app_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mixed_sample(mixed_sample),
    .cfg_ready   (cfg_ready)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allpass phaser effect testbench
// Drives audio samples and register writes into the phaser under several
// settings and idle patterns, and checks each output sample against a
// bit-exact predictor of the LFO, coefficient table, allpass cascade and mix.
// ----------------------------------------------------------------------------
module tb;

    import app_pkg::*;

    localparam int STAGES     = 4;
    localparam int TBL_BITS   = 10;
    localparam int TBL_SIZE   = 1 << TBL_BITS;
    localparam int FS_HZ      = 48000;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned LN2_Q30     = 64'd744261118;
    localparam longint INC_MIN   = 4474;
    localparam longint INC_MAX   = 447392;
    localparam longint FB_LIMIT  = 31129;
    localparam int SETTLE_CYCLES = 2 * STAGES + 12;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [23:0]        dry_sample;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [23:0]        mixed_sample;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [1:0]                cfg_index;
    logic [CFG_W-1:0]          cfg_data;

    allpass_phaser_effect_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .dry_sample   (dry_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mixed_sample (mixed_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predictor state and register copies.
    int             coeff_rom [TBL_SIZE];
    bit [18:0]      inc_reg;
    bit [16:0]      depth_reg;
    bit [15:0]      fb_reg;
    bit [16:0]      mix_reg;
    bit [31:0]      lfo_phase;
    longint         fb_sample;
    longint         stage_mem [STAGES];

    logic signed [23:0] sample_queue [$];
    logic signed [23:0] expected_mix [$];

    int send_idle;
    int recv_stall;
    int mismatches;
    int checked;
    int accepted;
    int phases_run;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clip24(input longint v);
        if (v > 8388607) begin
            return 8388607;
        end
        if (v < -8388608) begin
            return -8388608;
        end
        return v;
    endfunction

    // Rounded arithmetic shift, ties going up.
    function automatic longint round_shr(input longint v, input int n);
        longint r;
        r = (v + (longint'(1) <<< (n - 1))) >>> n;
        return r;
    endfunction

    function automatic longint unsigned log2_q30(input longint unsigned n);
        int k;
        longint unsigned m;
        longint unsigned r;
        k = 0;
        if (n == 0) begin
            n = 1;
        end
        while (k < 31 && (n >> (k + 1)) != 0) begin
            k++;
        end
        m = (k <= 30) ? (n << (30 - k)) : (n >> (k - 30));
        r = longint'(k) << 30;
        for (int i = 30; i > 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 2 * ONE_Q30) begin
                m = m >> 1;
                r = r | (64'd1 << (i - 1));
            end
        end
        return r;
    endfunction

    function automatic longint unsigned exp2_frac(input longint unsigned f);
        longint unsigned u;
        longint unsigned term;
        longint unsigned sum;
        u = (f * LN2_Q30) >> 30;
        term = ONE_Q30;
        sum = ONE_Q30;
        for (int k = 1; k <= 15; k++) begin
            term = ((term * u) >> 30) / k;
            sum += term;
        end
        return sum;
    endfunction

    // Allpass coefficient (t-1)/(t+1) from sine and cosine series.
    function automatic int coeff_of_angle(input longint unsigned theta);
        longint unsigned th2;
        longint unsigned ts;
        longint unsigned tc;
        longint s;
        longint c;
        longint num;
        longint den;
        if (theta > HALF_PI_Q30) begin
            theta = HALF_PI_Q30;
        end
        th2 = (theta * theta) >> 30;
        ts = theta;
        s = theta;
        tc = ONE_Q30;
        c = ONE_Q30;
        for (int k = 1; k <= 8; k++) begin
            ts = ((ts * th2) >> 30) / ((2 * k) * (2 * k + 1));
            tc = ((tc * th2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                s -= longint'(ts);
                c -= longint'(tc);
            end
            else begin
                s += longint'(ts);
                c += longint'(tc);
            end
        end
        num = s - c;
        den = s + c;
        if (den < 1) begin
            den = 1;
        end
        return int'(clip24((num * 8388608) / den));
    endfunction

    // Log-spaced sweep from 100 Hz to 4 kHz.
    function automatic void fill_coeff_rom();
        longint lmin;
        longint span;
        longint y;
        longint unsigned e;
        longint unsigned p;
        longint unsigned fq16;
        longint unsigned theta;
        lmin = log2_q30(100);
        span = longint'(log2_q30(4000)) - lmin;
        for (int i = 0; i < TBL_SIZE; i++) begin
            y = lmin + (span * i) / (TBL_SIZE - 1);
            if (y < 0) begin
                y = 0;
            end
            e = y >> 30;
            if (e > 16) begin
                e = 16;
            end
            p = exp2_frac(longint'(y) & (ONE_Q30 - 1));
            fq16 = (p << e) >> 14;
            if (fq16 > 64'h7FFFFFFF) begin
                fq16 = 64'h7FFFFFFF;
            end
            theta = ((fq16 * PI_Q30) / FS_HZ) >> 16;
            coeff_rom[i] = coeff_of_angle(theta);
        end
    endfunction

    // One sample through LFO, feedback, cascade and mix.
    function automatic logic signed [23:0] phaser_sample(input logic signed [23:0] dry_in);
        longint dry;
        longint g;
        longint depth;
        longint mix;
        longint inc;
        longint lfo;
        longint idx;
        longint a;
        longint x;
        longint y;
        dry = dry_in;
        g = longint'($signed(fb_reg));
        if (g > FB_LIMIT) begin
            g = FB_LIMIT;
        end
        if (g < -FB_LIMIT) begin
            g = -FB_LIMIT;
        end
        depth = (depth_reg > 65536) ? 65536 : depth_reg;
        mix = (mix_reg > 65536) ? 65536 : mix_reg;
        inc = inc_reg;
        if (inc < INC_MIN) begin
            inc = INC_MIN;
        end
        if (inc > INC_MAX) begin
            inc = INC_MAX;
        end
        lfo = (lfo_phase < 32'h80000000) ? (longint'(lfo_phase) >> 15)
                                         : ((64'd4294967296 - lfo_phase) >> 15);
        idx = ((lfo * depth) >> 16) >> (16 - TBL_BITS);
        if (idx > TBL_SIZE - 1) begin
            idx = TBL_SIZE - 1;
        end
        a = coeff_rom[idx];
        x = clip24(dry + round_shr(fb_sample * g, 15));
        for (int i = 0; i < STAGES; i++) begin
            y = clip24(stage_mem[i] - round_shr(a * x, 23));
            stage_mem[i] = clip24(x + round_shr(a * y, 23));
            x = y;
        end
        fb_sample = x;
        lfo_phase = lfo_phase + 32'(inc);
        y = clip24(round_shr(dry * (65536 - mix) + x * mix, 16));
        return y[23:0];
    endfunction

    // Sample driver: one pending sample at a time, random idle cycles.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_mix.push_back(phaser_sample(dry_sample));
                accepted++;
            end
            if (!in_valid || in_ready) begin
                if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                    in_valid <= 1'b1;
                    dry_sample <= sample_queue.pop_front();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each transaction with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_mix.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected output %0d", mixed_sample);
                    end
                end
                else begin
                    logic signed [23:0] want;
                    want = expected_mix.pop_front();
                    checked++;
                    if (mixed_sample !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mixed_sample mismatch: expected %0d got %0d",
                                     want, mixed_sample);
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_INC:   inc_reg = val[18:0];
            REG_DEPTH: depth_reg = val[16:0];
            REG_FB:    fb_reg = val[15:0];
            default:   mix_reg = val[16:0];
        endcase
    endtask

    task automatic write_all(input logic [18:0] inc, input logic [16:0] depth,
                             input logic [15:0] fb, input logic [16:0] mix);
        write_reg(REG_INC, inc);
        write_reg(REG_DEPTH, 19'(depth));
        write_reg(REG_FB, 19'(fb));
        write_reg(REG_MIX, 19'(mix));
    endtask

    // Wait for the block to drain before touching registers.
    task automatic drain();
        do begin
            @(posedge clk);
        end while (sample_queue.size() != 0 || in_valid || expected_mix.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [23:0] random_sample();
        logic signed [23:0] s;
        case ($urandom_range(9))
            0, 1, 2, 3: s = 24'($urandom);
            4, 5:       s = 24'($signed($urandom_range(8191)) - 4096);
            6:          s = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            7:          s = 24'($signed($urandom_range(65535)) + 8323072);
            default:    s = 24'(-$signed($urandom_range(65535)) - 8323072);
        endcase
        return s;
    endfunction

    initial
    begin
        fill_coeff_rom();
        inc_reg = 19'd44739;
        depth_reg = 17'd32768;
        fb_reg = 16'd0;
        mix_reg = 17'd32768;
        lfo_phase = 0;
        fb_sample = 0;
        foreach (stage_mem[i]) begin
            stage_mem[i] = 0;
        end
        send_idle = 0;
        recv_stall = 0;
        mismatches = 0;
        checked = 0;
        accepted = 0;
        phases_run = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        dry_sample = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_INC;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples under the reset settings: extremes and steps.
        foreach (sample_queue[i]) begin
        end
        sample_queue = '{24'sh000000, 24'sh7FFFFF, 24'sh800000, 24'shFFFFFF, 24'sh000001,
                         24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh400000,
                         24'shC00000, 24'sh555555, 24'shAAAAAA, 24'sh000000, 24'sh000000};
        drain();

        // Each phase: new settings (extremes first), new idle pattern, samples.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_all(19'd447392, 17'd65536, 16'd31129, 17'd65536);
                1: write_all(19'd0, 17'd131071, 16'h8000, 17'd0);
                2: write_all(19'h7FFFF, 17'd0, 16'h7FFF, 17'h1FFFF);
                3: write_all(19'd4474, 17'd65536, 16'($signed(-31129)), 17'd32768);
                default: write_all(19'($urandom), 17'($urandom), 16'($urandom),
                                   17'($urandom));
            endcase
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 50; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 50; end
                default: begin send_idle = 13; recv_stall = 13; end
            endcase
            // Loud feedback bursts first so the clamps get exercised.
            for (int i = 0; i < 8 && ph < 4; i++) begin
                sample_queue.push_back(i[0] ? 24'sh7FFFFF : 24'sh800000);
            end
            for (int i = 0; i < 175; i++) begin
                sample_queue.push_back(random_sample());
            end
            drain();
            phases_run++;
        end

        $display("Ran %0d register settings with four idle patterns.", phases_run + 1);
        $display("Accepted %0d samples and checked %0d outputs, %0d mismatches.",
                 accepted, checked, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
src/app_pkg.sv
src/app_ctrl.sv
src/app_dp.sv
src/allpass_phaser_effect_top.sv
src/app_checker.sv
bench/tb.sv
